/* rtl/gab_pkg.sv */
// Shared constants, request codes and controller/datapath interface types
// for the graph adjacency builder. No dependencies.
package gab_pkg;

  // Table sizes
  localparam int MAX_NODES    = 1024;
  localparam int MAX_SEGMENTS = 4096;
  localparam int SLOTS        = 8;

  // Field and counter widths
  localparam int NAME_W     = 32;
  localparam int NODE_W     = 10;
  localparam int NODE_CNT_W = 11;
  localparam int SLOT_W     = 3;
  localparam int SEG_W      = 12;
  localparam int SEG_CNT_W  = 13;
  localparam int DEG_W      = 4;
  localparam int KIND_W     = 2;
  localparam int TAB_DEPTH  = MAX_NODES * SLOTS;
  localparam int TAB_W      = NODE_W + SEG_W;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;

  localparam logic [DEG_W-1:0]      SLOTS_DEG     = DEG_W'(SLOTS);
  localparam logic [NODE_CNT_W-1:0] MAX_NODES_CNT = NODE_CNT_W'(MAX_NODES);
  localparam logic [SEG_CNT_W-1:0]  MAX_SEG_CNT   = SEG_CNT_W'(MAX_SEGMENTS);

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Controller to datapath commands, one step per controller state
  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic check;
    logic rd_a;
    logic upd_a;
    logic rd_b;
    logic upd_b;
    logic rd_q;
    logic q_wait;
    logic out_load;
  } gab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic both_found;
    logic seg_full;
    logic out_free;
  } gab_sts_t;

endpackage

/* rtl/gab_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module gab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gab_ctrl.sv */
// Controller state machine of the graph adjacency builder: sequences load,
// name scan, slot update and slot read steps. Depends on gab_pkg.
module gab_ctrl
  import gab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_tready,
  input  gab_sts_t          sts,
  output gab_cmd_t          cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_A_RD  = 4'd4;
  localparam logic [3:0] S_A_UPD = 4'd5;
  localparam logic [3:0] S_B_RD  = 4'd6;
  localparam logic [3:0] S_B_UPD = 4'd7;
  localparam logic [3:0] S_Q_RD  = 4'd8;
  localparam logic [3:0] S_Q_WT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and step commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          case (in_kind)
            KIND_LOAD: state_nxt = S_LOAD;
            KIND_SEG:  state_nxt = S_SCAN;
            KIND_READ: state_nxt = S_Q_RD;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.both_found ? S_A_RD : S_OUT;
      end
      S_A_RD: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_A_UPD;
      end
      S_A_UPD: begin
        cmd.upd_a = 1'b1;
        state_nxt = sts.seg_full ? S_OUT : S_B_RD;
      end
      S_B_RD: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_B_UPD;
      end
      S_B_UPD: begin
        cmd.upd_b = 1'b1;
        state_nxt = S_OUT;
      end
      S_Q_RD: begin
        cmd.rd_q  = 1'b1;
        state_nxt = S_Q_WT;
      end
      S_Q_WT: begin
        cmd.q_wait = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // A request is taken only from idle, and only one step runs at a time
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath step in a cycle");
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !sts.out_free) |=> (state_r == S_OUT))
    else $error("result left before the output register was free");
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(sts.scan_done))
    else $error("check entered before the scan finished");
`endif

endmodule

/* rtl/gab_dp.sv */
// Datapath of the graph adjacency builder: request registers, counters,
// name scan, degree and slot updates, output register. Depends on gab_pkg
// and gab_ram.
module gab_dp
  import gab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  gab_cmd_t              cmd,
  output gab_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]     in_kind,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Captured request
  logic [KIND_W-1:0] kind_r;
  logic [NAME_W-1:0] name_r;
  logic [NAME_W-1:0] start_r;
  logic [NAME_W-1:0] end_r;
  logic [NODE_W-1:0] qnode_r;
  logic [SLOT_W-1:0] qslot_r;

  // Counters
  logic [NODE_CNT_W-1:0] node_cnt_r;
  logic [SEG_CNT_W-1:0]  seg_cnt_r;

  // Scan state
  logic [NODE_CNT_W-1:0] scan_idx_r;
  logic                  cmp_vld_r;
  logic [NODE_W-1:0]     cmp_idx_r;
  logic                  fa_r;
  logic                  fb_r;

  // Result work registers
  logic [NODE_W-1:0] a_r;
  logic [NODE_W-1:0] b_r;
  logic [SEG_W-1:0]  seg_r;
  logic [DEG_W-1:0]  deg_r;
  logic              full_r;
  logic              ovf_r;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_DATA_W-1:0] res;

  // Memory ports
  logic              name_we;
  logic [NAME_W-1:0] name_rdata;
  logic              deg_we;
  logic [NODE_W-1:0] deg_waddr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [NODE_W-1:0] deg_raddr;
  logic [DEG_W-1:0]  deg_rdata;
  logic              tab_we;
  logic [NODE_W+SLOT_W-1:0] tab_waddr;
  logic [TAB_W-1:0]  tab_wdata;
  logic [TAB_W-1:0]  tab_rdata;

  logic node_room;
  logic deg_room;
  logic deg_inc_ok;

  assign node_room  = (node_cnt_r < MAX_NODES_CNT);
  assign deg_room   = (deg_rdata < SLOTS_DEG);
  assign deg_inc_ok = (cmd.upd_a && !full_r && deg_room) || (cmd.upd_b && deg_room);

  // Memory write and read port steering
  always_comb begin
    name_we   = cmd.load && node_room;
    deg_we    = name_we || deg_inc_ok;
    deg_waddr = node_cnt_r[NODE_W-1:0];
    deg_wdata = '0;
    tab_we    = deg_inc_ok;
    tab_waddr = {a_r, deg_rdata[SLOT_W-1:0]};
    tab_wdata = {b_r, seg_r};
    if (cmd.upd_a) begin
      deg_waddr = a_r;
      deg_wdata = deg_rdata + DEG_W'(1);
    end else if (cmd.upd_b) begin
      deg_waddr = b_r;
      deg_wdata = deg_rdata + DEG_W'(1);
      tab_waddr = {b_r, deg_rdata[SLOT_W-1:0]};
      tab_wdata = {a_r, seg_r};
    end
    deg_raddr = qnode_r;
    if (cmd.rd_a) begin
      deg_raddr = a_r;
    end else if (cmd.rd_b) begin
      deg_raddr = b_r;
    end
  end

  gab_ram #(.WIDTH(NAME_W), .DEPTH(MAX_NODES)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (node_cnt_r[NODE_W-1:0]),
    .wdata (name_r),
    .raddr (scan_idx_r[NODE_W-1:0]),
    .rdata (name_rdata)
  );

  gab_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gab_ram #(.WIDTH(TAB_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr ({qnode_r, qslot_r}),
    .rdata (tab_rdata)
  );

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      name_r  <= in_tdata[31:0];
      start_r <= in_tdata[63:32];
      end_r   <= in_tdata[95:64];
      qnode_r <= in_tdata[105:96];
      qslot_r <= in_tdata[108:106];
    end
  end

  // Counters: nodes stored and segments numbered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= '0;
      seg_cnt_r  <= '0;
    end else begin
      if (name_we) begin
        node_cnt_r <= node_cnt_r + NODE_CNT_W'(1);
      end
      if (cmd.check && fa_r && fb_r && (seg_cnt_r < MAX_SEG_CNT)) begin
        seg_cnt_r <= seg_cnt_r + SEG_CNT_W'(1);
      end
    end
  end

  // Name scan: issue one read a cycle, compare the data in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.capture) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= (scan_idx_r < node_cnt_r);
    end else begin
      cmp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_idx_r <= '0;
    end else if (cmd.scan && (scan_idx_r < node_cnt_r)) begin
      scan_idx_r <= scan_idx_r + NODE_CNT_W'(1);
    end
    cmp_idx_r <= scan_idx_r[NODE_W-1:0];
  end

  // Work registers of the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fa_r   <= 1'b0;
      fb_r   <= 1'b0;
      a_r    <= '0;
      b_r    <= '0;
      seg_r  <= '0;
      deg_r  <= '0;
      full_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      // keep the lowest matching index for each endpoint
      if (cmp_vld_r && !fa_r && (name_rdata == start_r)) begin
        fa_r <= 1'b1;
        a_r  <= cmp_idx_r;
      end
      if (cmp_vld_r && !fb_r && (name_rdata == end_r)) begin
        fb_r <= 1'b1;
        b_r  <= cmp_idx_r;
      end
      if (cmd.load) begin
        if (node_room) begin
          a_r <= node_cnt_r[NODE_W-1:0];
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.check && fa_r && fb_r) begin
        if (seg_cnt_r < MAX_SEG_CNT) begin
          seg_r <= seg_cnt_r[SEG_W-1:0];
        end else begin
          full_r <= 1'b1;
          ovf_r  <= 1'b1;
        end
      end
      if (cmd.upd_a) begin
        if (!full_r && deg_room) begin
          deg_r <= deg_rdata + DEG_W'(1);
        end else begin
          deg_r <= deg_rdata;
        end
        if (!full_r && !deg_room) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.upd_b) begin
        if (deg_room) begin
          // self loop: the start node takes both slots
          if (a_r == b_r) begin
            deg_r <= deg_rdata + DEG_W'(1);
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.q_wait) begin
        deg_r <= ({1'b0, qnode_r} < node_cnt_r) ? deg_rdata : '0;
        b_r   <= tab_rdata[TAB_W-1:SEG_W];
        seg_r <= tab_rdata[SEG_W-1:0];
      end
    end
  end

  // Assemble the result
  always_comb begin
    res = '0;
    case (kind_r)
      KIND_LOAD: begin
        res[9:0] = a_r;
        res[38]  = ovf_r;
      end
      KIND_SEG: begin
        res[9:0]   = a_r;
        res[19:10] = b_r;
        res[31:20] = seg_r;
        res[35:32] = deg_r;
        res[36]    = !fa_r;
        res[37]    = !fb_r;
        res[38]    = ovf_r;
      end
      KIND_READ: begin
        res[9:0]   = qnode_r;
        res[19:10] = b_r;
        res[31:20] = seg_r;
        res[35:32] = deg_r;
      end
      default: res = '0;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign sts.scan_done  = (scan_idx_r == node_cnt_r) && !cmp_vld_r;
  assign sts.both_found = fa_r && fb_r;
  assign sts.seg_full   = full_r;
  assign sts.out_free   = !out_tvalid_r || out_tready;

`ifndef SYNTH
  a_node_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    node_cnt_r <= MAX_NODES_CNT)
    else $error("node count above capacity");
  a_seg_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    seg_cnt_r <= MAX_SEG_CNT)
    else $error("segment count above capacity");
  a_slot_wr: assert property (@(posedge clk) disable iff (!rst_n)
    tab_we |-> (deg_we && deg_wdata <= SLOTS_DEG && !name_we))
    else $error("slot written without a matching degree step");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over one not yet taken");
`endif

endmodule

/* rtl/graph_adjacency_builder.sv */
// Graph adjacency builder top level. Load runs a load step; read runs a slot read
// and a wait step; segment runs the name scan, one name-store read per stored node,
// a check and, with both endpoints found, the slot updates; then the result loads.
// Throughput: one request at a time, the next taken the cycle after the result
// loads; a result waiting on out_tready holds the controller in its output step.
// Reset (rst_n, synchronous, active low) clears counts and controller state.
module graph_adjacency_builder
  import gab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] node_name, [63:32] start_name, [95:64] end_name,
  // [105:96] query_node, [108:106] query_slot, [111:109] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] node_index, [19:10] other_index, [31:20] segment_index,
  // [35:32] node_degree, [36] start_missing, [37] end_missing,
  // [38] overflow, [39] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  gab_cmd_t cmd;
  gab_sts_t sts;

  gab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gab_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/sv/graph_adjacency_builder_tb.sv */
// Testbench for graph_adjacency_builder: drives load, segment and read requests
// over the stream ports and checks every answer against a local adjacency model.
// Depends on gab_pkg and the graph_adjacency_builder RTL.
module graph_adjacency_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gab_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [NAME_W-1:0] NAME_ZERO   = 32'h0000_0000;
  localparam logic [NAME_W-1:0] NAME_ONES   = 32'hFFFF_FFFF;
  localparam logic [NAME_W-1:0] NAME_MID    = 32'hA5A5_A5A5;
  localparam logic [NAME_W-1:0] NAME_ABSENT = 32'h1234_5678;

  localparam int RANDOM_ITEMS   = 536;
  localparam int NODE_CAP_MIX   = 48;
  localparam int SETTLE_CYCLES  = 2 * MAX_NODES + 64;
  localparam int MAX_PRINTED    = 50;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  // Request fields, first field in the lowest bits
  typedef struct packed {
    logic [IN_DATA_W-SLOT_W-NODE_W-3*NAME_W-1:0] pad;
    logic [SLOT_W-1:0] query_slot;
    logic [NODE_W-1:0] query_node;
    logic [NAME_W-1:0] end_name;
    logic [NAME_W-1:0] start_name;
    logic [NAME_W-1:0] node_name;
  } adj_request_t;

  // Answer fields, first field in the lowest bits
  typedef struct packed {
    logic              pad;
    logic              overflow;
    logic              end_missing;
    logic              start_missing;
    logic [DEG_W-1:0]  degree;
    logic [SEG_W-1:0]  segment;
    logic [NODE_W-1:0] other;
    logic [NODE_W-1:0] node;
  } adj_result_t;

  bit                    clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = KIND_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Local copy of the adjacency tables
  logic [NAME_W-1:0] names_q [MAX_NODES];
  bit [DEG_W-1:0]    degrees [MAX_NODES];
  bit [NODE_W-1:0]   nbr_tab [TAB_DEPTH];
  bit [SEG_W-1:0]    seg_tab [TAB_DEPTH];
  int unsigned       node_total = 0;
  int unsigned       seg_total = 0;

  adj_result_t answers_due [$];
  int unsigned err_count = 0;
  int unsigned answers_seen = 0;
  int unsigned burst_left = 0;
  bit [9:0]    rx_phase = '0;

  graph_adjacency_builder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lowest stored index that holds the name
  function automatic bit find_node(input logic [NAME_W-1:0] name, output int unsigned idx);
    for (int unsigned i = 0; i < node_total; i++) begin
      if (names_q[i] == name) begin
        idx = i;
        return 1'b1;
      end
    end
    idx = 0;
    return 1'b0;
  endfunction

  // Record one connection in the node's next slot; refuse when all slots are used
  function automatic bit attach_slot(input int unsigned node, input int unsigned other,
                                     input int unsigned seg);
    int unsigned idx;
    if (degrees[node] >= SLOTS) return 1'b0;
    idx = node * SLOTS + degrees[node];
    nbr_tab[idx] = NODE_W'(other);
    seg_tab[idx] = SEG_W'(seg);
    degrees[node] = degrees[node] + DEG_W'(1);
    return 1'b1;
  endfunction

  // Apply one request to the local tables and return the answer it yields
  function automatic adj_result_t adjacency_step(input logic [KIND_W-1:0] kind,
                                                 input adj_request_t rq);
    adj_result_t r;
    int unsigned a, b;
    bit fa, fb, ok_a, ok_b;
    r = '0;
    case (kind)
      KIND_LOAD: begin
        if (node_total < MAX_NODES) begin
          names_q[node_total] = rq.node_name;
          r.node = NODE_W'(node_total);
          node_total++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      KIND_SEG: begin
        fa = find_node(rq.start_name, a);
        fb = find_node(rq.end_name, b);
        r.node = NODE_W'(a);
        r.other = NODE_W'(b);
        r.start_missing = !fa;
        r.end_missing = !fb;
        if (fa && fb) begin
          if (seg_total >= MAX_SEGMENTS) begin
            r.overflow = 1'b1;
          end else begin
            ok_a = attach_slot(a, b, seg_total);
            ok_b = attach_slot(b, a, seg_total);
            r.segment = SEG_W'(seg_total);
            r.overflow = !(ok_a && ok_b);
            seg_total++;
          end
          r.degree = degrees[a];
        end
      end
      KIND_READ: begin
        r.node = rq.query_node;
        r.degree = degrees[rq.query_node];
        r.other = nbr_tab[rq.query_node * SLOTS + rq.query_slot];
        r.segment = seg_tab[rq.query_node * SLOTS + rq.query_slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic adj_request_t random_fields();
    adj_request_t rq;
    rq.pad = '0;
    rq.query_slot = SLOT_W'($urandom);
    rq.query_node = NODE_W'($urandom);
    rq.end_name = $urandom;
    rq.start_name = $urandom;
    rq.node_name = $urandom;
    return rq;
  endfunction

  // Pick a slot that has been written, starting the search at a random node
  function automatic bit pick_written_slot(output int unsigned qn, output int unsigned qs);
    int unsigned first, n;
    qn = 0;
    qs = 0;
    if (node_total == 0) return 1'b0;
    first = $urandom_range(0, node_total - 1);
    for (int unsigned k = 0; k < node_total; k++) begin
      n = (first + k) % node_total;
      if (degrees[n] != 0) begin
        qn = n;
        qs = $urandom_range(0, degrees[n] - 1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Receiver readiness: always ready, mostly ready, fixed stall, coin flip
  function automatic bit rx_ready_now(input bit [9:0] ph);
    case (ph[9:8])
      2'd0: return 1'b1;
      2'd1: return ($urandom_range(0, 3) != 0);
      2'd2: return (ph[2:0] >= 3'd5);
      default: return $urandom_range(0, 1) != 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
    if (err_count < MAX_PRINTED)
      $display("[%0t] answer %0d %s: expected %0d, got %0d",
               $realtime, answers_seen, what, want, seen);
    err_count++;
  endtask

  // Compare one answer with the oldest pending one
  task automatic check_answer(input adj_result_t got);
    adj_result_t want;
    if (answers_due.size() == 0) begin
      report_mismatch("arrived with nothing pending", 0, 32'(got.node));
    end else begin
      want = answers_due.pop_front();
      if (got.node != want.node)
        report_mismatch("node_index", 32'(want.node), 32'(got.node));
      if (got.other != want.other)
        report_mismatch("other_index", 32'(want.other), 32'(got.other));
      if (got.segment != want.segment)
        report_mismatch("segment_index", 32'(want.segment), 32'(got.segment));
      if (got.degree != want.degree)
        report_mismatch("node_degree", 32'(want.degree), 32'(got.degree));
      if (got.start_missing != want.start_missing)
        report_mismatch("start_missing", 32'(want.start_missing), 32'(got.start_missing));
      if (got.end_missing != want.end_missing)
        report_mismatch("end_missing", 32'(want.end_missing), 32'(got.end_missing));
      if (got.overflow != want.overflow)
        report_mismatch("overflow", 32'(want.overflow), 32'(got.overflow));
    end
    answers_seen++;
  endtask

  // Take answers and advance the stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_answer(out_tdata);
    rx_phase <= rx_phase + 10'd1;
    out_tready <= rx_ready_now(rx_phase);
  end

  // Offer one request, in bursts with random gaps, and predict once it is taken
  task automatic send_request(input logic [KIND_W-1:0] kind, input adj_request_t rq);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= rq;
    burst_left--;
    do @(posedge clk); while (!in_tready);
    answers_due.push_back(adjacency_step(kind, rq));
  endtask

  task automatic send_load(input logic [NAME_W-1:0] name);
    adj_request_t rq;
    rq = random_fields();
    rq.node_name = name;
    send_request(KIND_LOAD, rq);
  endtask

  task automatic send_seg(input logic [NAME_W-1:0] start_name,
                          input logic [NAME_W-1:0] end_name);
    adj_request_t rq;
    rq = random_fields();
    rq.start_name = start_name;
    rq.end_name = end_name;
    send_request(KIND_SEG, rq);
  endtask

  task automatic send_read(input int unsigned qn, input int unsigned qs);
    adj_request_t rq;
    rq = random_fields();
    rq.query_node = NODE_W'(qn);
    rq.query_slot = SLOT_W'(qs);
    send_request(KIND_READ, rq);
  endtask

  task automatic send_spare();
    send_request(KIND_SPARE, random_fields());
  endtask

  // Hold the sender until every pending answer has arrived
  task automatic wait_answers_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Extreme names, duplicate name, missing endpoints, self loop, full node slots
  task automatic test_directed_basics();
    send_load(NAME_ZERO);
    send_load(NAME_ONES);
    send_load(NAME_MID);
    send_load(NAME_ZERO);
    send_seg(NAME_ZERO, NAME_ONES);
    send_seg(NAME_ONES, NAME_MID);
    send_seg(NAME_MID, NAME_MID);
    send_seg(NAME_ABSENT, NAME_ZERO);
    send_seg(NAME_ONES, NAME_ABSENT);
    send_seg(NAME_ABSENT, ~NAME_ABSENT);
    for (int unsigned s = 0; s < 3; s++) send_read(2, s);
    send_read(0, 0);
    send_spare();
    // fill node 0 with self loops until both ends are refused
    repeat (5) send_seg(NAME_ZERO, NAME_ZERO);
    send_read(0, SLOTS - 1);
  endtask

  // Mostly well-formed traffic on a small graph, with some noise
  task automatic test_random_mix();
    int unsigned pick, a, b, qn, qs, done;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      a = $urandom_range(0, node_total - 1);
      b = $urandom_range(0, node_total - 1);
      done++;
      if (pick < 12 && node_total < NODE_CAP_MIX) begin
        send_load($urandom);
      end else if (pick < 55) begin
        send_seg(names_q[a], names_q[b]);
      end else if (pick < 85 && pick_written_slot(qn, qs)) begin
        send_read(qn, qs);
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0: send_seg($urandom, names_q[b]);
          1: send_seg(names_q[a], $urandom);
          default: send_seg($urandom, $urandom);
        endcase
      end else if (pick < 97) begin
        send_spare();
        done--;
      end else begin
        send_seg(names_q[a], names_q[a]);
      end
    end
  endtask

  // Drain everything, then restart from an idle block with a short tail
  task automatic test_pause_and_tail();
    wait_answers_done();
    send_seg(names_q[1], NAME_ABSENT);
    send_read(0, SLOTS - 1);
    send_spare();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_random_mix();
    test_pause_and_tail();
    wait_answers_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("graph_adjacency_builder_tb: clean");
    end else begin
      $display("graph_adjacency_builder_tb: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d answers pending", answers_due.size());
    $display("graph_adjacency_builder_tb: errors");
    $finish;
  end

endmodule
